/* rtl/tlptm_pkg.sv */
// Shared types and constants of the two-level page table manager.
package tlptm_pkg;

    // Field widths of one transaction
    localparam int OP_W   = 3;
    localparam int WORD_W = 32;
    localparam int ATTR_W = 12;

    // Virtual address split: directory slot, table slot, page offset
    localparam int SLOT_W     = 10;
    localparam int DSLOT_LSB  = 22;
    localparam int TSLOT_LSB  = 12;
    localparam int OFFSET_W   = 12;

    localparam logic [WORD_W-1:0] FRAME_MASK  = 32'hFFFF_F000;
    localparam logic [WORD_W-1:0] PRESENT_BIT = 32'h0000_0001;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TRANSLATE = 3'd0,
        OP_MAP       = 3'd1,
        OP_UNMAP     = 3'd2,
        OP_CLEAR     = 3'd3,
        OP_EXISTS    = 3'd4,
        OP_SET_DIR   = 3'd5
    } t_op;

endpackage

/* rtl/two_level_page_table_manager_unit.sv */
// Top level of the two-level page table manager: directory and page table memories with sequencer.
//
// The block keeps a page directory of DIR_ENTRIES words and one page table of TABLE_ENTRIES
// words for every directory slot, both in RAMs with a registered read port. Every transaction
// gives exactly one result. Translate, map, unmap, table-exists and set-directory first accept
// and launch the directory and table reads in parallel, then decide and write back. Clear table
// walks the slot's table, if present, one entry per cycle through the table RAM's write port.
// One transaction is in flight at a time; a finished result sits in an output register, and
// the next transaction is accepted while it waits to be taken. After reset both memories are
// zeroed by a sweep over all DIR_ENTRIES * TABLE_ENTRIES table addresses (1048576 with the
// default sizes), during which o_ready stays low.
module two_level_page_table_manager_unit #(
    parameter int DIR_ENTRIES   = 1024,
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [tlptm_pkg::OP_W-1:0]      i_op,
    input  logic [tlptm_pkg::WORD_W-1:0]    i_virtual_address,
    input  logic [tlptm_pkg::WORD_W-1:0]    i_phys_address,
    input  logic [tlptm_pkg::ATTR_W-1:0]    i_attr,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_ok,
    output logic [tlptm_pkg::WORD_W-1:0]    o_phys_out
);

    localparam int DW    = $clog2(DIR_ENTRIES);
    localparam int TOTAL = DIR_ENTRIES * TABLE_ENTRIES;
    localparam int AW    = $clog2(TOTAL);

    logic                          dir_we, dir_re;
    logic [DW-1:0]                 dir_waddr, dir_raddr;
    logic [tlptm_pkg::WORD_W-1:0]  dir_wdata, dir_rdata;
    logic                          tab_we, tab_re;
    logic [AW-1:0]                 tab_waddr, tab_raddr;
    logic [tlptm_pkg::WORD_W-1:0]  tab_wdata, tab_rdata;

    // Page directory
    tlptm_ram #(
        .WIDTH (tlptm_pkg::WORD_W),
        .DEPTH (DIR_ENTRIES)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_re    (dir_re),
        .i_raddr (dir_raddr),
        .o_rdata (dir_rdata)
    );

    // All page tables, slot-major
    tlptm_ram #(
        .WIDTH (tlptm_pkg::WORD_W),
        .DEPTH (TOTAL)
    ) u_tab_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_re    (tab_re),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    // Sequencer
    tlptm_ctrl #(
        .DIR_ENTRIES   (DIR_ENTRIES),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .DW            (DW),
        .AW            (AW)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_op              (i_op),
        .i_virtual_address (i_virtual_address),
        .i_phys_address    (i_phys_address),
        .i_attr            (i_attr),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_ok              (o_ok),
        .o_phys_out        (o_phys_out),
        .o_dir_we          (dir_we),
        .o_dir_waddr       (dir_waddr),
        .o_dir_wdata       (dir_wdata),
        .o_dir_re          (dir_re),
        .o_dir_raddr       (dir_raddr),
        .i_dir_rdata       (dir_rdata),
        .o_tab_we          (tab_we),
        .o_tab_waddr       (tab_waddr),
        .o_tab_wdata       (tab_wdata),
        .o_tab_re          (tab_re),
        .o_tab_raddr       (tab_raddr),
        .i_tab_rdata       (tab_rdata)
    );

endmodule

/* rtl/tlptm_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module tlptm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read; a read in the same cycle as a write sees old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tlptm_ctrl.sv */
// Sequencer of the page table manager: decode, read-modify-write, table clear, result register.
module tlptm_ctrl #(
    parameter int DIR_ENTRIES   = 1024,
    parameter int TABLE_ENTRIES = 1024,
    parameter int DW            = $clog2(DIR_ENTRIES),
    parameter int AW            = $clog2(DIR_ENTRIES * TABLE_ENTRIES)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [tlptm_pkg::OP_W-1:0]      i_op,
    input  logic [tlptm_pkg::WORD_W-1:0]    i_virtual_address,
    input  logic [tlptm_pkg::WORD_W-1:0]    i_phys_address,
    input  logic [tlptm_pkg::ATTR_W-1:0]    i_attr,
    // output channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_ok,
    output logic [tlptm_pkg::WORD_W-1:0]    o_phys_out,
    // directory memory
    output logic                            o_dir_we,
    output logic [DW-1:0]                   o_dir_waddr,
    output logic [tlptm_pkg::WORD_W-1:0]    o_dir_wdata,
    output logic                            o_dir_re,
    output logic [DW-1:0]                   o_dir_raddr,
    input  logic [tlptm_pkg::WORD_W-1:0]    i_dir_rdata,
    // page table memory
    output logic                            o_tab_we,
    output logic [AW-1:0]                   o_tab_waddr,
    output logic [tlptm_pkg::WORD_W-1:0]    o_tab_wdata,
    output logic                            o_tab_re,
    output logic [AW-1:0]                   o_tab_raddr,
    input  logic [tlptm_pkg::WORD_W-1:0]    i_tab_rdata
);

    localparam int TW    = $clog2(TABLE_ENTRIES);
    localparam int SW    = tlptm_pkg::SLOT_W;
    localparam int WW    = tlptm_pkg::WORD_W;
    localparam int TOTAL = DIR_ENTRIES * TABLE_ENTRIES;

    localparam logic [AW-1:0] TAB_STRIDE = AW'(TABLE_ENTRIES);
    localparam logic [AW-1:0] INIT_LAST  = AW'(TOTAL - 1);
    localparam logic [AW-1:0] DIR_SPAN   = AW'(DIR_ENTRIES);
    localparam logic [TW-1:0] CLEAR_LAST = TW'(TABLE_ENTRIES - 1);
    localparam logic [SW:0]   DIR_LIMIT  = (SW+1)'(DIR_ENTRIES);
    localparam logic [SW:0]   TAB_LIMIT  = (SW+1)'(TABLE_ENTRIES);

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_CLEAR = 5'b01000,
        S_HOLD  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_init_pos, n_init_pos;
    logic [TW-1:0]       r_clear_pos, n_clear_pos;

    // captured transaction
    logic [tlptm_pkg::OP_W-1:0]   r_op;
    logic [WW-1:0]                r_va;
    logic [WW-1:0]                r_pa;
    logic [tlptm_pkg::ATTR_W-1:0] r_attr;
    logic                         r_dir_ok;
    logic                         r_tab_ok;
    logic [AW-1:0]                r_tab_base;
    logic [AW-1:0]                r_tab_addr;

    // result register and waiting result
    logic                r_out_valid, n_out_valid;
    logic                r_ok, n_ok;
    logic [WW-1:0]       r_phys, n_phys;
    logic                r_pend_ok;
    logic [WW-1:0]       r_pend_phys;

    logic [SW-1:0]       in_dslot, in_tslot;
    logic [AW-1:0]       in_base;
    logic                in_fire;
    logic                out_free;
    logic                present;

    // results of the execute step
    logic                ex_dir_we;
    logic                ex_tab_we;
    logic [WW-1:0]       ex_tab_wdata;
    logic                res_fire;
    logic                res_ok;
    logic [WW-1:0]       res_phys;

    assign in_dslot = i_virtual_address[tlptm_pkg::DSLOT_LSB +: SW];
    assign in_tslot = i_virtual_address[tlptm_pkg::TSLOT_LSB +: SW];
    assign in_base  = AW'(in_dslot[DW-1:0]) * TAB_STRIDE;
    assign in_fire  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign present  = r_dir_ok && (i_dir_rdata != '0);

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_ok       = r_ok;
    assign o_phys_out = r_phys;

    // Issue both lookups on the accepted transaction
    assign o_dir_re    = in_fire;
    assign o_dir_raddr = in_dslot[DW-1:0];
    assign o_tab_re    = in_fire;
    assign o_tab_raddr = in_base + AW'(in_tslot[TW-1:0]);

    // Decide the outcome once directory word and table entry are back
    always_comb begin
        ex_dir_we    = 1'b0;
        ex_tab_we    = 1'b0;
        ex_tab_wdata = '0;
        res_fire     = 1'b0;
        res_ok       = 1'b0;
        res_phys     = '0;
        if (r_state == S_EXEC) begin
            res_fire = 1'b1;
            case (r_op)
                tlptm_pkg::OP_TRANSLATE: begin
                    if (present && r_tab_ok && (i_tab_rdata != '0)) begin
                        res_ok   = 1'b1;
                        res_phys = {i_tab_rdata[WW-1:tlptm_pkg::OFFSET_W],
                                    r_va[tlptm_pkg::OFFSET_W-1:0]};
                    end
                end
                tlptm_pkg::OP_MAP: begin
                    if (present && r_tab_ok && (i_tab_rdata == '0)) begin
                        ex_tab_we    = 1'b1;
                        ex_tab_wdata = r_pa | WW'(r_attr) | tlptm_pkg::PRESENT_BIT;
                        res_ok       = 1'b1;
                    end
                end
                tlptm_pkg::OP_UNMAP: begin
                    if (present && r_tab_ok) begin
                        ex_tab_we = 1'b1;
                        res_ok    = 1'b1;
                    end
                end
                tlptm_pkg::OP_CLEAR: begin
                    // a present table is walked first; the result follows the walk
                    res_fire = !present;
                end
                tlptm_pkg::OP_EXISTS: begin
                    res_ok = present;
                end
                tlptm_pkg::OP_SET_DIR: begin
                    if (r_dir_ok) begin
                        ex_dir_we = 1'b1;
                        res_ok    = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else if ((r_state == S_CLEAR) && (r_clear_pos == CLEAR_LAST)) begin
            res_fire = 1'b1;
            res_ok   = 1'b1;
        end
    end

    // Steer the write ports: reset sweep, table walk or single update
    always_comb begin
        o_dir_we    = 1'b0;
        o_dir_waddr = r_va[tlptm_pkg::DSLOT_LSB +: DW];
        o_dir_wdata = (r_pa & tlptm_pkg::FRAME_MASK) | WW'(r_attr);
        o_tab_we    = 1'b0;
        o_tab_waddr = r_tab_addr;
        o_tab_wdata = ex_tab_wdata;
        case (r_state)
            S_INIT: begin
                o_dir_we    = (r_init_pos < DIR_SPAN);
                o_dir_waddr = r_init_pos[DW-1:0];
                o_dir_wdata = '0;
                o_tab_we    = 1'b1;
                o_tab_waddr = r_init_pos;
                o_tab_wdata = '0;
            end
            S_CLEAR: begin
                o_tab_we    = 1'b1;
                o_tab_waddr = r_tab_base + AW'(r_clear_pos);
                o_tab_wdata = '0;
            end
            S_EXEC: begin
                o_dir_we = ex_dir_we;
                o_tab_we = ex_tab_we;
            end
            default: begin
            end
        endcase
    end

    // Advance the sequencer and the result register
    always_comb begin
        n_state     = r_state;
        n_init_pos  = r_init_pos;
        n_clear_pos = r_clear_pos;
        n_out_valid = r_out_valid && !i_ready;
        n_ok        = r_ok;
        n_phys      = r_phys;
        case (r_state)
            S_INIT: begin
                n_init_pos = r_init_pos + 1'b1;
                if (r_init_pos == INIT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!res_fire) begin
                    n_state     = S_CLEAR;
                    n_clear_pos = '0;
                end
            end
            S_CLEAR: begin
                n_clear_pos = r_clear_pos + 1'b1;
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_ok        = r_pend_ok;
                    n_phys      = r_pend_phys;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        // hand a finished result to the output register, or park it
        if (res_fire) begin
            if (out_free) begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_ok        = res_ok;
                n_phys      = res_phys;
            end else begin
                n_state = S_HOLD;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_pos  <= '0;
            r_clear_pos <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_pos  <= n_init_pos;
            r_clear_pos <= n_clear_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ok   <= n_ok;
        r_phys <= n_phys;
        if (res_fire) begin
            r_pend_ok   <= res_ok;
            r_pend_phys <= res_phys;
        end
        if (in_fire) begin
            r_op       <= i_op;
            r_va       <= i_virtual_address;
            r_pa       <= i_phys_address;
            r_attr     <= i_attr;
            r_dir_ok   <= ({1'b0, in_dslot} < DIR_LIMIT);
            r_tab_ok   <= ({1'b0, in_tslot} < TAB_LIMIT);
            r_tab_base <= in_base;
            r_tab_addr <= in_base + AW'(in_tslot[TW-1:0]);
        end
    end

endmodule
